>>> src/tgc_pkg.sv
// Shared types, codes and constants of the touch gesture classifier.
package tgc_pkg;

    localparam int PAD_COUNT = 3;
    localparam logic [2:0] PAD_MASK = 3'((1 << PAD_COUNT) - 1);

    localparam int MS_W    = 16;
    localparam int TAP_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Result event codes.
    localparam logic [2:0] EV_SHORT      = 3'd0;
    localparam logic [2:0] EV_SHORT_RUN  = 3'd1;
    localparam logic [2:0] EV_LONG_A     = 3'd2;
    localparam logic [2:0] EV_LONG_B     = 3'd3;
    localparam logic [2:0] EV_RUN_END    = 3'd4;
    localparam logic [2:0] EV_TAPS_LONG  = 3'd5;
    localparam logic [2:0] EV_THREE_FIVE = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_A_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_B_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_WINDOW = 3'd5;

    // Configuration reset values.
    localparam logic [MS_W-1:0] SHORT_MIN_RST    = 16'd20;
    localparam logic [MS_W-1:0] LONG_A_MIN_RST   = 16'd3000;
    localparam logic [MS_W-1:0] LONG_B_MIN_RST   = 16'd10000;
    localparam logic [MS_W-1:0] MAX_HOLD_RST     = 16'd60000;
    localparam logic [MS_W-1:0] TAP_WINDOW_RST   = 16'd400;
    localparam logic [MS_W-1:0] COMBO_WINDOW_RST = 16'd3000;

    // Tap counts that take part in the combination gestures.
    localparam logic [TAP_W-1:0] COMBO_LONG_TAPS  = 8'd3;
    localparam logic [TAP_W-1:0] COMBO_FIRST_RUN  = 8'd3;
    localparam logic [TAP_W-1:0] COMBO_SECOND_RUN = 8'd5;
    localparam logic [TAP_W-1:0] TAP_MAX          = 8'd255;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       func;
        logic [2:0] pads;
    } scan_item_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [2:0]       pad_pattern;
        logic [TAP_W-1:0] tap_count;
        logic             last;
    } gesture_item_t;

endpackage

>>> src/touch_gesture_classifier.sv
// Touch gesture classifier: press timing, tap runs and combination gestures.
//
//   channel   direction  handshake                       payload
//   scan      in         scan_valid / scan_stall         scan_item (func, pads)
//   gesture   out        gesture_valid / gesture_stall   gesture_item
//   cfg       in         cfg_we                          cfg_index, cfg_data
//
// Each accepted item updates the whole state in one pass of logic at its edge,
// and its zero, one or two results can be taken from the cycle after that edge.
// A four-entry queue sends one result per cycle unless the receiver stalls;
// scan_stall is high while it holds three or more results, so the input waits
// only when results arrive faster than one per cycle or the receiver stalls.
// Reset clears the state and the queue and loads the configuration defaults.
module touch_gesture_classifier
    import tgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 scan_valid,
    output logic                 scan_stall,
    input  scan_item_t           scan_item,
    output logic                 gesture_valid,
    input  logic                 gesture_stall,
    output gesture_item_t        gesture_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MS_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [MS_W-1:0] short_min_reg, long_a_min_reg, long_b_min_reg;
    logic [MS_W-1:0] max_hold_reg, tap_window_reg, combo_window_reg;

    // Gesture state and its next values.
    logic [MS_W-1:0]  hold_cd_reg, hold_cd_next;
    logic [MS_W-1:0]  tap_win_reg, tap_win_next;
    logic [MS_W-1:0]  combo_win_reg, combo_win_next;
    logic             pressed_reg, pressed_next;
    logic [2:0]       latched_reg, latched_next;
    logic             long_a_done_reg, long_a_done_next;
    logic             long_b_done_reg, long_b_done_next;
    logic [TAP_W-1:0] taps_reg, taps_next;
    logic [TAP_W-1:0] run_cnt_reg, run_cnt_next;
    logic             cl_armed_reg, cl_armed_next;
    logic [2:0]       cl_pads_reg, cl_pads_next;
    logic             c5_armed_reg, c5_armed_next;
    logic [2:0]       c5_pads_reg, c5_pads_next;

    // Result queue.
    gesture_item_t    fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic             accept;
    logic             pop;
    logic [2:0]       pads_m;
    logic [MS_W-1:0]  held;
    logic             cond_a, cond_b;
    logic [TAP_W-1:0] taps_v, run_v;
    logic [2:0]       kind_v;
    logic [1:0]       n_res;
    gesture_item_t    res0, res1, run_res;

    assign accept = scan_valid && !scan_stall;
    assign pop    = gesture_valid && !gesture_stall;
    assign pads_m = scan_item.pads & PAD_MASK;

    // Hold time saturates at zero if the countdown is above the limit, which
    // happens when the limit is lowered during a press.
    assign held = (hold_cd_reg > max_hold_reg) ? '0 : max_hold_reg - hold_cd_reg;

    assign cond_a = (held > long_a_min_reg) && (held <= long_b_min_reg) && !long_a_done_reg;
    assign cond_b = (held > long_b_min_reg) && (held <= max_hold_reg) && !long_b_done_reg;

    always_comb
    begin
        hold_cd_next     = hold_cd_reg;
        tap_win_next     = tap_win_reg;
        combo_win_next   = combo_win_reg;
        pressed_next     = pressed_reg;
        latched_next     = latched_reg;
        long_a_done_next = long_a_done_reg;
        long_b_done_next = long_b_done_reg;
        taps_next        = taps_reg;
        run_cnt_next     = run_cnt_reg;
        cl_armed_next    = cl_armed_reg;
        cl_pads_next     = cl_pads_reg;
        c5_armed_next    = c5_armed_reg;
        c5_pads_next     = c5_pads_reg;
        taps_v           = taps_reg;
        run_v            = run_cnt_reg;
        kind_v           = EV_SHORT;
        res0             = '0;
        res1             = '0;
        run_res          = '0;
        n_res            = 2'd0;

        if (accept)
        begin
            if (scan_item.func)
            begin
                // Millisecond tick: count the three timers down.
                if (hold_cd_reg != '0)
                begin
                    hold_cd_next = hold_cd_reg - 1'b1;
                end
                if (tap_win_reg != '0)
                begin
                    tap_win_next = tap_win_reg - 1'b1;
                end
                if (combo_win_reg != '0)
                begin
                    combo_win_next = combo_win_reg - 1'b1;
                end
            end
            else
            begin
                // An expired combination window disarms the five-tap gesture.
                if (combo_win_reg == '0)
                begin
                    c5_armed_next = 1'b0;
                    c5_pads_next  = '0;
                end

                if (pads_m != '0)
                begin
                    if (!pressed_reg)
                    begin
                        pressed_next = 1'b1;
                        hold_cd_next = max_hold_reg;
                        tap_win_next = tap_window_reg;
                        latched_next = pads_m;
                    end
                    else if (pads_m == latched_reg)
                    begin
                        // The two long thresholds exclude each other, so at
                        // most one long event fires per sample.
                        if (cond_a || cond_b)
                        begin
                            long_a_done_next = long_a_done_reg || cond_a;
                            long_b_done_next = long_b_done_reg || cond_b;
                            if (cond_a && cl_armed_reg && (latched_reg == cl_pads_reg))
                            begin
                                kind_v = EV_TAPS_LONG;
                            end
                            else if (cond_a)
                            begin
                                kind_v = EV_LONG_A;
                            end
                            else
                            begin
                                kind_v = EV_LONG_B;
                            end
                            res0.event_res   = kind_v;
                            res0.pad_pattern = latched_reg;
                            n_res            = 2'd1;
                            run_cnt_next     = 8'd1;
                            cl_armed_next    = 1'b0;
                            cl_pads_next     = '0;
                            c5_armed_next    = 1'b0;
                            c5_pads_next     = '0;
                        end
                    end
                    else if (held < short_min_reg)
                    begin
                        // A pattern change early in a press restarts it.
                        hold_cd_next = max_hold_reg;
                        tap_win_next = tap_window_reg;
                        latched_next = pads_m;
                    end
                end
                else
                begin
                    if (pressed_reg && (held > short_min_reg) && (held <= long_a_min_reg))
                    begin
                        if ((tap_win_reg != '0) && (taps_reg != TAP_MAX))
                        begin
                            taps_v = taps_reg + 1'b1;
                        end
                        res0.pad_pattern = latched_reg;
                        n_res            = 2'd1;
                        if (taps_v <= 8'd1)
                        begin
                            res0.event_res = EV_SHORT;
                            run_cnt_next   = 8'd1;
                            cl_armed_next  = 1'b0;
                            cl_pads_next   = '0;
                        end
                        else
                        begin
                            res0.event_res = EV_SHORT_RUN;
                            if (run_cnt_reg != TAP_MAX)
                            begin
                                run_v = run_cnt_reg + 1'b1;
                            end
                            run_cnt_next = run_v;
                            if (run_v == COMBO_LONG_TAPS)
                            begin
                                cl_armed_next = 1'b1;
                                cl_pads_next  = latched_reg;
                            end
                            else
                            begin
                                cl_armed_next = 1'b0;
                                cl_pads_next  = '0;
                            end
                        end
                    end
                    taps_next = taps_v;

                    // Tap window over: close the run.
                    if ((tap_win_reg == '0) && (taps_v != '0))
                    begin
                        taps_next = '0;
                        if (taps_v >= 8'd2)
                        begin
                            run_res.pad_pattern = latched_reg;
                            run_res.tap_count   = taps_v;
                            run_res.event_res   = EV_RUN_END;
                            if (taps_v == COMBO_FIRST_RUN)
                            begin
                                c5_armed_next  = 1'b1;
                                c5_pads_next   = latched_reg;
                                combo_win_next = combo_window_reg;
                            end
                            else
                            begin
                                if ((taps_v == COMBO_SECOND_RUN) && c5_armed_next
                                    && (latched_reg == c5_pads_next))
                                begin
                                    run_res.event_res = EV_THREE_FIVE;
                                end
                                c5_armed_next = 1'b0;
                                c5_pads_next  = '0;
                            end
                            run_cnt_next  = 8'd1;
                            cl_armed_next = 1'b0;
                            cl_pads_next  = '0;
                            if (n_res == 2'd0)
                            begin
                                res0  = run_res;
                                n_res = 2'd1;
                            end
                            else
                            begin
                                res1  = run_res;
                                n_res = 2'd2;
                            end
                        end
                        latched_next = '0;
                    end
                    long_a_done_next = 1'b0;
                    long_b_done_next = 1'b0;
                    hold_cd_next     = '0;
                    pressed_next     = 1'b0;
                end
            end
        end

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg    <= SHORT_MIN_RST;
            long_a_min_reg   <= LONG_A_MIN_RST;
            long_b_min_reg   <= LONG_B_MIN_RST;
            max_hold_reg     <= MAX_HOLD_RST;
            tap_window_reg   <= TAP_WINDOW_RST;
            combo_window_reg <= COMBO_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_MIN:    short_min_reg    <= cfg_data;
                CFG_LONG_A_MIN:   long_a_min_reg   <= cfg_data;
                CFG_LONG_B_MIN:   long_b_min_reg   <= cfg_data;
                CFG_MAX_HOLD:     max_hold_reg     <= cfg_data;
                CFG_TAP_WINDOW:   tap_window_reg   <= cfg_data;
                CFG_COMBO_WINDOW: combo_window_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Gesture state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cd_reg     <= '0;
            tap_win_reg     <= '0;
            combo_win_reg   <= '0;
            pressed_reg     <= 1'b0;
            latched_reg     <= '0;
            long_a_done_reg <= 1'b0;
            long_b_done_reg <= 1'b0;
            taps_reg        <= '0;
            run_cnt_reg     <= 8'd1;
            cl_armed_reg    <= 1'b0;
            cl_pads_reg     <= '0;
            c5_armed_reg    <= 1'b0;
            c5_pads_reg     <= '0;
        end
        else
        begin
            hold_cd_reg     <= hold_cd_next;
            tap_win_reg     <= tap_win_next;
            combo_win_reg   <= combo_win_next;
            pressed_reg     <= pressed_next;
            latched_reg     <= latched_next;
            long_a_done_reg <= long_a_done_next;
            long_b_done_reg <= long_b_done_next;
            taps_reg        <= taps_next;
            run_cnt_reg     <= run_cnt_next;
            cl_armed_reg    <= cl_armed_next;
            cl_pads_reg     <= cl_pads_next;
            c5_armed_reg    <= c5_armed_next;
            c5_pads_reg     <= c5_pads_next;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(n_res) - CNT_W'(pop);
        end
    end

    // Room for two results is needed before an item is taken.
    assign scan_stall    = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign gesture_valid = (count_reg != '0);
    assign gesture_item  = fifo_mem[rd_ptr_reg];

endmodule

>>> src/tgc_checker.sv
// Port-level checks for the touch gesture classifier, bound to the top level.
module tgc_checker
    import tgc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 gesture_valid,
    input logic                 gesture_stall,
    input gesture_item_t        gesture_item
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && gesture_stall |=> gesture_valid && $stable(gesture_item))
    else $error("stalled gesture item changed");

    // Only a release gives two results, and its first one is a tap.
    assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && !gesture_item.last |->
            (gesture_item.event_res == EV_SHORT) || (gesture_item.event_res == EV_SHORT_RUN))
    else $error("non-final item is not a tap");

    // Press events carry no tap count.
    assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture_item.event_res != EV_RUN_END)
            && (gesture_item.event_res != EV_THREE_FIVE) |-> gesture_item.tap_count == '0)
    else $error("press event with a tap count");

    // A tap run holds at least two taps.
    assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture_item.event_res == EV_RUN_END) |->
            gesture_item.tap_count >= 8'd2)
    else $error("tap run end with fewer than two taps");

    // The three-then-five gesture closes a run of five.
    assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture_item.event_res == EV_THREE_FIVE) |->
            gesture_item.tap_count == COMBO_SECOND_RUN)
    else $error("three-then-five without five taps");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);

>>> tb/sv/tb_touch_gesture_classifier.sv
// Self-checking testbench of the touch gesture classifier: random gestures, scoreboard.
module tb_touch_gesture_classifier;

    import tgc_pkg::*;

    // Generous bound on the whole run; the slowest correct run needs a small fraction.
    localparam int CYCLE_LIMIT   = 400000;
    // Cycles the receiver refuses results in one stretch, so that the result
    // queue fills and the block has to stall its scan input.
    localparam int HOLD_OFF_LEN  = 400;
    // Longest press or window (in ticks) that one gesture spends; large
    // register settings are clamped to this so that runs stay short.
    localparam int TICK_CAP      = 16;
    localparam int LONG_TICK_CAP = 40;

    // The scoreboard keeps its own copy of the classifier: the timing
    // registers, the press and tap-run state, and the gestures still due.
    class gesture_scoreboard;

        logic [MS_W-1:0]  short_min, long_a_min, long_b_min, max_hold;
        logic [MS_W-1:0]  tap_window, combo_window;

        logic [MS_W-1:0]  hold_cd, tap_left, combo_left;
        logic             pressed, long_a_seen, long_b_seen;
        logic [2:0]       held_pads;
        logic [TAP_W-1:0] run_taps, run_presses;
        logic             long_armed, five_armed;
        logic [2:0]       long_pads, five_pads;

        gesture_item_t    gestures_due[$];
        gesture_item_t    step_gestures[$];
        int               mismatch_count;

        function void clear();
            short_min    = SHORT_MIN_RST;
            long_a_min   = LONG_A_MIN_RST;
            long_b_min   = LONG_B_MIN_RST;
            max_hold     = MAX_HOLD_RST;
            tap_window   = TAP_WINDOW_RST;
            combo_window = COMBO_WINDOW_RST;
            hold_cd      = '0;
            tap_left     = '0;
            combo_left   = '0;
            pressed      = 1'b0;
            long_a_seen  = 1'b0;
            long_b_seen  = 1'b0;
            held_pads    = '0;
            run_taps     = '0;
            run_presses  = 8'd1;
            long_armed   = 1'b0;
            long_pads    = '0;
            five_armed   = 1'b0;
            five_pads    = '0;
            mismatch_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [MS_W-1:0] value);
            case (index)
                CFG_SHORT_MIN:    short_min    = value;
                CFG_LONG_A_MIN:   long_a_min   = value;
                CFG_LONG_B_MIN:   long_b_min   = value;
                CFG_MAX_HOLD:     max_hold     = value;
                CFG_TAP_WINDOW:   tap_window   = value;
                CFG_COMBO_WINDOW: combo_window = value;
                default: ;
            endcase
        endfunction

        // Measured hold; zero when the countdown was loaded from a larger max_hold.
        function logic [MS_W-1:0] hold_ms();
            return (hold_cd > max_hold) ? '0 : MS_W'(max_hold - hold_cd);
        endfunction

        function void push_gesture(logic [2:0] code, logic [2:0] pat, logic [TAP_W-1:0] taps);
            gesture_item_t g;
            g.event_res   = code;
            g.pad_pattern = pat;
            g.tap_count   = taps;
            g.last        = 1'b0;
            step_gestures.push_back(g);
        endfunction

        function void disarm_long();
            long_armed = 1'b0;
            long_pads  = '0;
        endfunction

        function void disarm_five();
            five_armed = 1'b0;
            five_pads  = '0;
        endfunction

        function void classify_press(logic [2:0] pat, logic [2:0] kind);
            if (kind == EV_SHORT_RUN)
            begin
                if (run_presses != TAP_MAX)
                    run_presses++;
                if (run_presses == COMBO_LONG_TAPS)
                begin
                    long_armed = 1'b1;
                    long_pads  = pat;
                end
                else
                    disarm_long();
                push_gesture(EV_SHORT_RUN, pat, '0);
                return;
            end
            if (kind == EV_LONG_A && long_armed && pat == long_pads)
                push_gesture(EV_TAPS_LONG, pat, '0);
            else
                push_gesture(kind, pat, '0);
            run_presses = 8'd1;
            disarm_long();
            if (kind != EV_SHORT)
                disarm_five();
        endfunction

        function void close_run(logic [2:0] pat, logic [TAP_W-1:0] n);
            if (n == COMBO_FIRST_RUN)
            begin
                push_gesture(EV_RUN_END, pat, n);
                five_armed = 1'b1;
                five_pads  = pat;
                combo_left = combo_window;
            end
            else if (n == COMBO_SECOND_RUN && five_armed && pat == five_pads)
                push_gesture(EV_THREE_FIVE, pat, n);
            else
                push_gesture(EV_RUN_END, pat, n);
            run_presses = 8'd1;
            disarm_long();
            if (n != COMBO_FIRST_RUN)
                disarm_five();
        endfunction

        // Applies one accepted scan item and queues the gestures it causes.
        function void take_scan(scan_item_t scan);
            logic [2:0]       pads;
            logic [MS_W-1:0]  held;
            logic [TAP_W-1:0] n;
            gesture_item_t    g;
            int               i;
            pads = scan.pads & PAD_MASK;
            step_gestures.delete();
            if (scan.func)
            begin
                if (hold_cd != 0)
                    hold_cd--;
                if (tap_left != 0)
                    tap_left--;
                if (combo_left != 0)
                    combo_left--;
                return;
            end
            if (combo_left == 0)
                disarm_five();
            if (pads != 0)
            begin
                if (!pressed)
                begin
                    pressed   = 1'b1;
                    hold_cd   = max_hold;
                    tap_left  = tap_window;
                    held_pads = pads;
                end
                else if (pads == held_pads)
                begin
                    held = hold_ms();
                    if (held > long_a_min && held <= long_b_min && !long_a_seen)
                    begin
                        long_a_seen = 1'b1;
                        classify_press(held_pads, EV_LONG_A);
                    end
                    if (held > long_b_min && held <= max_hold && !long_b_seen)
                    begin
                        long_b_seen = 1'b1;
                        classify_press(held_pads, EV_LONG_B);
                    end
                end
                else if (hold_ms() < short_min)
                begin
                    hold_cd   = max_hold;
                    tap_left  = tap_window;
                    held_pads = pads;
                end
            end
            else
            begin
                if (pressed)
                begin
                    held = hold_ms();
                    if (held > short_min && held <= long_a_min)
                    begin
                        if (tap_left != 0 && run_taps != TAP_MAX)
                            run_taps++;
                        classify_press(held_pads, (run_taps <= 8'd1) ? EV_SHORT : EV_SHORT_RUN);
                    end
                end
                if (tap_left == 0 && run_taps != 0)
                begin
                    n = run_taps;
                    run_taps = '0;
                    if (n >= 8'd2)
                        close_run(held_pads, n);
                    held_pads = '0;
                end
                long_a_seen = 1'b0;
                long_b_seen = 1'b0;
                hold_cd     = '0;
                pressed     = 1'b0;
            end
            for (i = 0; i < step_gestures.size(); i++)
            begin
                g = step_gestures[i];
                g.last = (i == step_gestures.size() - 1);
                gestures_due.push_back(g);
            end
        endfunction

        function void report_mismatch(string what, gesture_item_t want, gesture_item_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("MISMATCH %s: expected ev=%0d pads=%0d taps=%0d last=%0d, ",
                         what, want.event_res, want.pad_pattern, want.tap_count, want.last,
                         "got ev=%0d pads=%0d taps=%0d last=%0d",
                         got.event_res, got.pad_pattern, got.tap_count, got.last);
        endfunction

        function void check_gesture(gesture_item_t got);
            gesture_item_t want;
            if (gestures_due.size() == 0)
            begin
                report_mismatch("unexpected result", '0, got);
                return;
            end
            want = gestures_due.pop_front();
            if (got.event_res !== want.event_res || got.pad_pattern !== want.pad_pattern ||
                got.tap_count !== want.tap_count || got.last !== want.last)
                report_mismatch("wrong result", want, got);
        endfunction

    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 scan_valid;
    logic                 scan_stall;
    scan_item_t           scan_item;
    logic                 gesture_valid;
    logic                 gesture_stall;
    gesture_item_t        gesture_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_data;

    gesture_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_left;
    int cycle_count;
    int hold_off_left;
    bit hold_off_req;

    touch_gesture_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan_valid    (scan_valid),
        .scan_stall    (scan_stall),
        .scan_item     (scan_item),
        .gesture_valid (gesture_valid),
        .gesture_stall (gesture_stall),
        .gesture_item  (gesture_item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a run that is still going at the limit has hung somewhere.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side. Values are sampled right after the edge, which still shows
    // what the block saw at that edge. The stall is then redrawn for the next
    // cycle, or held high for a long stretch when the main flow asks for it.
    initial
    begin
        gesture_stall = 1'b0;
        hold_off_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && gesture_valid && !gesture_stall)
                sb.check_gesture(gesture_item);
            if (hold_off_req)
            begin
                hold_off_left = HOLD_OFF_LEN;
                hold_off_req  = 1'b0;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                gesture_stall <= 1'b1;
            end
            else
                gesture_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic int cap_ms(int value, int most);
        return (value > most) ? most : value;
    endfunction

    // Offers one item, with random idle cycles ahead of it, and returns at the
    // edge that takes it. Valid stays high when the next item follows at once.
    task automatic send_scan(input logic func, input logic [2:0] pads);
        scan_item_t item;
        item.func = func;
        item.pads = pads;
        while ($urandom_range(99) < send_idle_pct)
        begin
            scan_valid <= 1'b0;
            @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan_item  <= item;
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        sb.take_scan(item);
        items_left--;
    endtask

    // Ticks carry random pad bits, which the block must ignore.
    task automatic send_ticks(input int n);
        repeat (n)
            send_scan(1'b1, 3'($urandom));
    endtask

    // One press: touch, hold for the given ticks with repeated samples of the
    // same pattern now and then, and release.
    task automatic press(input logic [2:0] pat, input int hold, input int sample_pct);
        send_scan(1'b0, pat);
        repeat (hold)
        begin
            send_ticks(1);
            if ($urandom_range(99) < sample_pct)
                send_scan(1'b0, pat);
        end
        send_scan(1'b0, 3'b000);
    endtask

    // Lets the continuation window run out and releases, which ends a tap run.
    task automatic close_window();
        send_ticks(cap_ms(int'(sb.tap_window), TICK_CAP) + 1);
        send_scan(1'b0, 3'b000);
    endtask

    task automatic tap_run(input logic [2:0] pat, input int taps, input bit close);
        repeat (taps)
        begin
            press(pat, cap_ms(int'(sb.short_min) + $urandom_range(1, 2), TICK_CAP), 20);
            send_ticks($urandom_range(0, 1));
        end
        if (close)
            close_window();
    endtask

    // Hold long enough for long A, long B or past max_hold, picked at random.
    task automatic long_press(input logic [2:0] pat, input int reach);
        int hold;
        case (reach)
            0:       hold = $urandom_range(int'(sb.long_a_min) + 1, int'(sb.long_b_min));
            1:       hold = $urandom_range(int'(sb.long_b_min) + 1, int'(sb.max_hold));
            default: hold = int'(sb.max_hold) + $urandom_range(1, 4);
        endcase
        press(pat, cap_ms(hold, LONG_TICK_CAP), 50);
    endtask

    // Mostly well-formed gestures with random content, the rest noise.
    task automatic play_gesture();
        logic [2:0] pat;
        int         kind;
        pat  = 3'($urandom_range(1, 7));
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
                tap_run(pat, $urandom_range(1, 6), 1'b1);
            3:
            begin
                // A run of three, then a run of five on the same pads.
                tap_run(pat, 3, 1'b1);
                tap_run(pat, 5, 1'b1);
            end
            4:
            begin
                // Three taps, then a long hold on the same pads before the run ends.
                tap_run(pat, 3, 1'b0);
                long_press(pat, 0);
                close_window();
            end
            5, 6:
                long_press(pat, $urandom_range(0, 2));
            7:
            begin
                // Pattern change: early enough to restart the press, or ignored.
                send_scan(1'b0, pat);
                send_ticks($urandom_range(0, cap_ms(int'(sb.short_min) + 1, TICK_CAP)));
                send_scan(1'b0, 3'($urandom_range(1, 7)));
                send_ticks($urandom_range(0, cap_ms(int'(sb.short_min) + 2, TICK_CAP)));
                send_scan(1'b0, 3'b000);
            end
            default:
                repeat ($urandom_range(2, 6))
                    send_scan(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        endcase
    endtask

    // Waits until every predicted result has come, then idles on so that items
    // without results have surely been applied as well.
    task automatic settle();
        scan_valid <= 1'b0;
        while (sb.gestures_due.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic load_config(input int s_min, input int la_min, input int lb_min,
                               input int m_hold, input int tap_w, input int combo_w);
        logic [MS_W-1:0]      vals [6];
        logic [CFG_IDX_W-1:0] regs [6];
        int                   i;
        vals[0] = MS_W'(s_min);   regs[0] = CFG_SHORT_MIN;
        vals[1] = MS_W'(la_min);  regs[1] = CFG_LONG_A_MIN;
        vals[2] = MS_W'(lb_min);  regs[2] = CFG_LONG_B_MIN;
        vals[3] = MS_W'(m_hold);  regs[3] = CFG_MAX_HOLD;
        vals[4] = MS_W'(tap_w);   regs[4] = CFG_TAP_WINDOW;
        vals[5] = MS_W'(combo_w); regs[5] = CFG_COMBO_WINDOW;
        for (i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_register(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // One block of random gestures; optionally ends with the pads still held,
    // so that the next setting takes effect in the middle of a press.
    task automatic run_gestures(input int budget, input bit leave_pressed);
        items_left = budget;
        while (items_left > 0)
            play_gesture();
        if (leave_pressed)
            send_scan(1'b0, 3'($urandom_range(1, 7)));
        settle();
    endtask

    initial
    begin
        sb = new;
        sb.clear();
        rst_n         = 1'b0;
        scan_valid    = 1'b0;
        scan_item     = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 70;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with tiny timings: a tick with all pads set, three
        // quick taps that arm the taps-then-long gesture, a long hold that
        // completes it and goes on to long B, and a release that ends the run
        // of three. Then a pattern change that comes too late to restart.
        load_config(0, 2, 3, 5, 3, 20);
        send_scan(1'b1, 3'b111);
        repeat (3)
            press(3'b101, 1, 0);
        press(3'b101, 4, 100);
        send_scan(1'b0, 3'b010);
        send_scan(1'b0, 3'b100);
        send_scan(1'b0, 3'b000);
        settle();

        // Sender idles less than the receiver.
        load_config(2, 8, 14, 20, 10, 80);
        run_gestures(200, 1'b0);

        // The other way round, with one long receiver hold-off at the start.
        send_idle_pct = 70;
        recv_idle_pct = 38;
        load_config(0, 4, 9, 12, 6, 60);
        hold_off_req = 1'b1;
        run_gestures(170, 1'b1);

        // No idling from here on; extreme settings at both ends.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(0, 0, 0, 0, 0, 0);
        run_gestures(50, 1'b0);
        load_config(65535, 65535, 65535, 65535, 65535, 65535);
        run_gestures(50, 1'b1);

        // max_hold drops below the countdown of the press still held, and
        // long B lies beyond max_hold.
        load_config(1, 5, 30, 12, 8, 50);
        run_gestures(130, 1'b0);

        repeat (16)
            @(posedge clk);
        if (sb.mismatch_count == 0 && sb.gestures_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
src/tgc_pkg.sv
src/touch_gesture_classifier.sv
src/tgc_checker.sv
tb/sv/tb_touch_gesture_classifier.sv
